FILE: rtl/telemetry_frame_handler_top_macros.svh
// assertion macros used by the telemetry frame handler checker
// no dependencies
`ifndef TELEMETRY_FRAME_HANDLER_TOP_MACROS_SVH
`define TELEMETRY_FRAME_HANDLER_TOP_MACROS_SVH

// checked outside reset
`define TFH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define TFH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/tfh_pkg.sv
// shared types and constants of the telemetry frame handler
// no dependencies
package tfh_pkg;

  localparam int unsigned FrameBytes = 20;
  localparam int unsigned PosW       = 5;
  localparam int unsigned GainWords  = 3;

  localparam logic [PosW-1:0] PosIdle  = PosW'(FrameBytes);
  localparam logic [PosW-1:0] PosCheck = PosW'(FrameBytes - 1);
  localparam logic [PosW-1:0] PosCmd   = PosW'(2);
  localparam logic [PosW-1:0] PosGain0 = PosW'(3);
  localparam logic [PosW-1:0] PosGainN = PosW'(14);

  localparam logic [7:0] HdrByte0  = 8'h46;
  localparam logic [7:0] HdrByte1  = 8'h43;
  localparam logic [7:0] SumInit   = 8'hFF;
  localparam logic [7:0] CmdSetA   = 8'h00;
  localparam logic [7:0] CmdRead   = 8'h10;
  localparam logic [7:0] CmdSetB   = 8'h20;
  localparam logic [7:0] CmdMode   = 8'h30;
  localparam logic [7:0] ModeCountRst = 8'd9;

  typedef logic [GainWords-1:0][31:0] gain_words_t;

  // ieee single 4e-4, 2e-6, 7e-3 (word 0 in the low bits)
  localparam gain_words_t GainRst = {32'h3BE56042, 32'h360637BD, 32'h39D1B717};

  typedef struct packed {
    logic start;
    logic is_mode;
  } reply_launch_t;

endpackage

FILE: rtl/tfh_reply_tx.sv
// reply frame generator: streams one 20-byte reply per launch
// depends on tfh_pkg
module tfh_reply_tx
  import tfh_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  reply_launch_t launch_i,
  input  gain_words_t   gains_i,
  input  logic [7:0]    mode_i,
  output logic          busy_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [7:0]    m_axis_tdata,
  output logic          m_axis_tlast
);

  logic            busy_q, busy_d;
  logic            kind_q, kind_d;
  logic [PosW-1:0] idx_q, idx_d;
  logic [7:0]      sum_q, sum_d;
  logic [3:0]      rel;
  logic [7:0]      gain_byte;
  logic [7:0]      tx_byte;
  logic            beat;

  assign rel = 4'(idx_q - PosGain0);

  always_comb begin
    gain_byte = 8'h00;
    case (rel[3:2])
      2'd0: gain_byte = gains_i[0][{rel[1:0], 3'b000} +: 8];
      2'd1: gain_byte = gains_i[1][{rel[1:0], 3'b000} +: 8];
      2'd2: gain_byte = gains_i[2][{rel[1:0], 3'b000} +: 8];
      default: gain_byte = 8'h00;
    endcase
  end

  always_comb begin
    tx_byte = 8'h00;
    if (idx_q == 5'd0) begin
      tx_byte = HdrByte0;
    end else if (idx_q == 5'd1) begin
      tx_byte = HdrByte1;
    end else if (idx_q == PosCmd) begin
      tx_byte = kind_q ? CmdMode : CmdSetB;
    end else if (idx_q == PosCheck) begin
      tx_byte = sum_q;
    end else if (kind_q) begin
      tx_byte = (idx_q == PosGain0) ? mode_i : 8'h00;
    end else if (idx_q <= PosGainN) begin
      tx_byte = gain_byte;
    end
  end

  assign beat = busy_q && m_axis_tready;

  always_comb begin
    busy_d = busy_q;
    kind_d = kind_q;
    idx_d  = idx_q;
    sum_d  = sum_q;
    if (launch_i.start) begin
      busy_d = 1'b1;
      kind_d = launch_i.is_mode;
      idx_d  = '0;
      sum_d  = SumInit;
    end else if (beat) begin
      sum_d = sum_q - tx_byte;
      idx_d = idx_q + 5'd1;
      if (idx_q == PosCheck) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      kind_q <= 1'b0;
      idx_q  <= '0;
      sum_q  <= SumInit;
    end else begin
      busy_q <= busy_d;
      kind_q <= kind_d;
      idx_q  <= idx_d;
      sum_q  <= sum_d;
    end
  end

  assign busy_o        = busy_q;
  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = tx_byte;
  assign m_axis_tlast  = (idx_q == PosCheck);

endmodule

FILE: rtl/telemetry_frame_handler_top.sv
// telemetry frame handler top level: frame receiver, command decode, reply
// depends on tfh_pkg and tfh_reply_tx
//
// usage:
//  s_axis: one received frame byte per beat in tdata, tuser marks byte 0 of a
//  frame. the running checksum, command id and gain bytes are updated in the
//  accepting cycle. on byte 19 the checksum is compared. a good frame with
//  command 0x00, 0x10, 0x20, or 0x30 with a valid mode code, starts a 20-byte
//  reply on m_axis the next cycle (tlast on the checksum byte). one reply byte
//  per cycle while the receiver is ready.
//  s_axis takes a byte every cycle; only byte 19 of a frame is held off while
//  the previous reply is still going out, since a frame needs 20 beats this
//  only happens when m_axis stalls.
//  cfg: cfg_we_i writes mode_count from cfg_wdata_i; write only while idle.
//  reset: no frame open, gains back to defaults, mode 0, mode_count 9,
//  no reply pending. a stalled reply byte holds on m_axis.
module telemetry_frame_handler_top
  import tfh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic       s_axis_tuser,   // [0] frame_first
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
  output logic       m_axis_tlast
);

  logic [7:0]      mode_count_q;
  logic [PosW-1:0] pos_q, pos_d, pos_eff;
  logic [7:0]      sum_q, sum_d, sum_eff;
  logic [7:0]      cmd_q, cmd_d;
  gain_words_t     pend_q, pend_d;
  gain_words_t     gain_q, gain_d;
  logic [7:0]      mode_q, mode_d;
  logic [3:0]      rel;
  logic            tx_busy;
  logic            accept;
  reply_launch_t   launch;

  // byte 19 may go in together with the last beat of the previous reply
  assign s_axis_tready = !(tx_busy && !(m_axis_tready && m_axis_tlast) && pos_q == PosCheck);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign pos_eff = s_axis_tuser ? '0 : pos_q;
  assign sum_eff = s_axis_tuser ? SumInit : sum_q;
  assign rel     = 4'(pos_eff - PosGain0);

  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    cmd_d  = cmd_q;
    pend_d = pend_q;
    gain_d = gain_q;
    mode_d = mode_q;
    launch = '0;
    if (accept) begin
      pos_d = pos_eff;
      sum_d = sum_eff;
      if (pos_eff == PosCheck) begin
        pos_d = PosIdle;
        if (s_axis_tdata == sum_eff) begin
          case (cmd_q)
            CmdSetA, CmdSetB: begin
              gain_d       = pend_q;
              launch.start = 1'b1;
            end
            CmdRead: begin
              launch.start = 1'b1;
            end
            CmdMode: begin
              if (pend_q[0][7:0] < mode_count_q) begin
                mode_d         = pend_q[0][7:0];
                launch.start   = 1'b1;
                launch.is_mode = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end else if (pos_eff < PosCheck) begin
        sum_d = sum_eff - s_axis_tdata;
        pos_d = pos_eff + 5'd1;
        if (pos_eff == PosCmd) begin
          cmd_d = s_axis_tdata;
        end else if (pos_eff >= PosGain0 && pos_eff <= PosGainN) begin
          // little-endian capture, byte 3 is the low byte of word 0
          pend_d[rel[3:2]][{rel[1:0], 3'b000} +: 8] = s_axis_tdata;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_count_q <= ModeCountRst;
      pos_q        <= PosIdle;
      sum_q        <= SumInit;
      cmd_q        <= '0;
      gain_q       <= GainRst;
      mode_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_count_q <= cfg_wdata_i;
      end
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      cmd_q  <= cmd_d;
      gain_q <= gain_d;
      mode_q <= mode_d;
    end
  end

  // captured gain bytes carry no reset
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  tfh_reply_tx u_reply_tx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .launch_i      (launch),
    .gains_i       (gain_q),
    .mode_i        (mode_q),
    .busy_o        (tx_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: rtl/tfh_checker.sv
// port-level checker for the telemetry frame handler, bound to the top level
// depends on tfh_pkg and telemetry_frame_handler_top_macros.svh
`include "telemetry_frame_handler_top_macros.svh"

module tfh_checker
  import tfh_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic       m_axis_tlast
);

  logic       in_beat;
  logic       out_stall;
  logic       out_last_beat;
  logic       hdr_ok;
  logic [8:0] out_word;

  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_stall     = m_axis_tvalid && !m_axis_tready;
  assign out_last_beat = m_axis_tvalid && m_axis_tready && m_axis_tlast;
  assign hdr_ok        = (m_axis_tdata == HdrByte0);
  assign out_word      = {m_axis_tlast, m_axis_tdata};

  // nothing goes out while reset is held
  `TFH_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !m_axis_tvalid, "reply during reset")

  // a stalled beat holds
  `TFH_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_word), "beat changed")

  // a reply starts with the header and only after an input beat
  `TFH_ASSERT(a_reply_start, $rose(m_axis_tvalid) |-> hdr_ok && $past(in_beat), "bad start")

  // after the last beat the output idles unless a byte came in
  `TFH_ASSERT(a_gap_after_last, out_last_beat && !in_beat |=> !m_axis_tvalid, "stray reply")

endmodule

bind telemetry_frame_handler_top tfh_checker u_tfh_checker (.*);

FILE: verif/tb_top.sv
// self-checking bench for telemetry_frame_handler_top: command frames in, reply beats out
// scoreboard class mirrors the frame receiver and predicts reply beats
// depends on tfh_pkg and the rtl of the block
typedef struct packed {
  logic [7:0] tx_byte;
  logic       tx_last;
} reply_beat_t;

class reply_scoreboard;
  logic [4:0]          rx_pos;
  logic [7:0]          rx_sum;
  logic [7:0]          rx_cmd;
  logic [7:0]          mode_limit;
  logic [7:0]          op_mode;
  tfh_pkg::gain_words_t staged_gains;
  tfh_pkg::gain_words_t live_gains;
  reply_beat_t         reply_q[$];
  int                  errors;

  function new();
    rx_pos       = tfh_pkg::PosIdle;
    rx_sum       = tfh_pkg::SumInit;
    rx_cmd       = 8'h00;
    mode_limit   = tfh_pkg::ModeCountRst;
    op_mode      = 8'h00;
    staged_gains = '0;
    live_gains   = tfh_pkg::GainRst;
    errors       = 0;
  endfunction

  function void set_mode_limit(logic [7:0] v);
    mode_limit = v;
  endfunction

  function int pending();
    return reply_q.size();
  endfunction

  function void queue_reply(logic [18:0][7:0] body);
    logic [7:0] csum;
    csum = tfh_pkg::SumInit;
    for (int k = 0; k < 19; k++) begin
      reply_q.push_back('{tx_byte: body[k], tx_last: 1'b0});
      csum = csum - body[k];
    end
    reply_q.push_back('{tx_byte: csum, tx_last: 1'b1});
  endfunction

  function void close_frame(logic [7:0] check);
    logic [18:0][7:0] body;
    if (check != rx_sum) return;
    body    = '0;
    body[0] = tfh_pkg::HdrByte0;
    body[1] = tfh_pkg::HdrByte1;
    if (rx_cmd == tfh_pkg::CmdSetA || rx_cmd == tfh_pkg::CmdRead ||
        rx_cmd == tfh_pkg::CmdSetB) begin
      if (rx_cmd != tfh_pkg::CmdRead) live_gains = staged_gains;
      body[2] = tfh_pkg::CmdSetB;
      for (int w = 0; w < 3; w++) begin
        for (int b = 0; b < 4; b++) begin
          body[3 + w * 4 + b] = live_gains[w][8 * b +: 8];
        end
      end
      queue_reply(body);
    end else if (rx_cmd == tfh_pkg::CmdMode && staged_gains[0][7:0] < mode_limit) begin
      op_mode = staged_gains[0][7:0];
      body[2] = tfh_pkg::CmdMode;
      body[3] = op_mode;
      queue_reply(body);
    end
  endfunction

  function void note_rx_byte(logic [7:0] b, logic first);
    int rel;
    if (first) begin
      rx_pos = 5'd0;
      rx_sum = tfh_pkg::SumInit;
    end
    if (rx_pos >= tfh_pkg::PosIdle) return;
    if (rx_pos == tfh_pkg::PosCheck) begin
      rx_pos = tfh_pkg::PosIdle;
      close_frame(b);
      return;
    end
    rx_sum = rx_sum - b;
    if (rx_pos == tfh_pkg::PosCmd) begin
      rx_cmd = b;
    end else if (rx_pos >= tfh_pkg::PosGain0 && rx_pos <= tfh_pkg::PosGainN) begin
      rel = int'(rx_pos) - 3;
      staged_gains[rel >> 2][8 * (rel & 3) +: 8] = b;
    end
    rx_pos = rx_pos + 5'd1;
  endfunction

  function void check_tx_beat(logic [7:0] b, logic last);
    reply_beat_t exp_beat;
    if (reply_q.size() == 0) begin
      $display("%0t: unexpected reply beat, actual byte %02h last %0b", $time, b, last);
      errors++;
      return;
    end
    exp_beat = reply_q.pop_front();
    if (b !== exp_beat.tx_byte) begin
      $display("%0t: tx_byte expected %02h actual %02h", $time, exp_beat.tx_byte, b);
      errors++;
    end
    if (last !== exp_beat.tx_last) begin
      $display("%0t: tx_last expected %0b actual %0b", $time, exp_beat.tx_last, last);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import tfh_pkg::*;

  typedef logic [19:0][7:0] frame_t;

  localparam int IdleLimit   = 3000;
  localparam int SettleWait  = 40;
  localparam int PhaseItems  = 40;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  reply_scoreboard sb;
  bit         no_idle;
  logic [7:0] mode_cfg;
  int         sent_items;
  int         quiet_cycles;

  telemetry_frame_handler_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sink side: random stalls between bursts of ready
  initial begin
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // both handshakes are sampled here; replies are checked before the new byte is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_tx_beat(m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready) sb.note_rx_byte(s_axis_tdata, s_axis_tuser);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic first);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
  endtask

  task automatic send_frame(input frame_t frm, input int count);
    for (int k = 0; k < count; k++) push_byte(frm[k], k == 0);
  endtask

  function automatic frame_t seal(input frame_t frm);
    logic [7:0] s;
    s = SumInit;
    for (int k = 0; k < 19; k++) s = s - frm[k];
    frm[19] = s;
    return frm;
  endfunction

  function automatic frame_t plain_frame(input logic [7:0] cmd, input logic [7:0] fill);
    frame_t frm;
    frm    = '0;
    frm[0] = HdrByte0;
    frm[1] = HdrByte1;
    frm[2] = cmd;
    for (int k = 3; k <= 14; k++) frm[k] = fill;
    return frm;
  endfunction

  function automatic frame_t random_frame(input logic [7:0] cmd);
    frame_t frm;
    int r;
    for (int k = 0; k < 20; k++) frm[k] = 8'($urandom);
    if ($urandom_range(0, 9) != 0) frm[0] = HdrByte0;
    if ($urandom_range(0, 9) != 0) frm[1] = HdrByte1;
    frm[2] = cmd;
    if (cmd == CmdMode) begin
      r = $urandom_range(0, 9);
      if (r < 6) frm[3] = 8'($urandom_range(0, int'(mode_cfg) - 1));
      else if (r == 6) frm[3] = mode_cfg - 8'd1;
      else if (r == 7) frm[3] = mode_cfg;
    end
    return seal(frm);
  endfunction

  task automatic random_step();
    frame_t frm;
    logic [7:0] cmd;
    int r;
    case ($urandom_range(0, 5))
      0:       cmd = CmdSetA;
      1:       cmd = CmdRead;
      2:       cmd = CmdSetB;
      3, 4:    cmd = CmdMode;
      default: cmd = 8'($urandom);
    endcase
    frm = random_frame(cmd);
    r = $urandom_range(0, 99);
    if (r < 75) begin
      send_frame(frm, 20);
    end else if (r < 85) begin
      frm[19] = frm[19] ^ 8'($urandom_range(1, 255));
      send_frame(frm, 20);
    end else if (r < 93) begin
      // cut short, the next marker abandons it
      send_frame(frm, $urandom_range(1, 19));
    end else begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_mode_count(input logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    mode_cfg = v;
    sb.set_mode_limit(v);
  endtask

  initial begin
    frame_t     frm;
    logic [7:0] limits[4];
    int         start;
    sb            = new();
    no_idle       = 1'b0;
    mode_cfg      = ModeCountRst;
    sent_items    = 0;
    quiet_cycles  = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 8'h00;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: defaults read back, gain extremes, mode edges, drops
    send_frame(seal(plain_frame(CmdRead, 8'h00)), 20);
    send_frame(seal(plain_frame(CmdSetA, 8'hFF)), 20);
    send_frame(seal(plain_frame(CmdSetB, 8'h00)), 20);
    frm = plain_frame(CmdMode, 8'h00);
    frm[3] = mode_cfg - 8'd1;
    send_frame(seal(frm), 20);
    frm[3] = mode_cfg;
    send_frame(seal(frm), 20);
    frm[3] = 8'h00;
    send_frame(seal(frm), 20);
    frm = seal(plain_frame(CmdRead, 8'h5A));
    frm[19] = ~frm[19];
    send_frame(frm, 20);
    send_frame(seal(plain_frame(8'hFF, 8'hA5)), 20);
    // bytes with no frame open, then a marker in the middle of a frame
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    send_frame(seal(plain_frame(CmdSetA, 8'h3C)), 7);
    send_frame(random_frame(CmdSetA), 20);

    limits[0] = 8'd255;
    limits[1] = 8'd1;
    limits[2] = 8'($urandom_range(2, 254));
    limits[3] = ModeCountRst;
    for (int p = 0; p < 4; p++) begin
      settle();
      write_mode_count(limits[p]);
      no_idle = (p == 2);
      start = sent_items;
      while (sent_items - start < PhaseItems) random_step();
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
